// File: rtl/sfvg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfvg_pkg
// Shared types and codes of the stroke font vector generator.
// ----------------------------------------------------------------------------
package sfvg_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned CodeW   = 7;
  localparam int unsigned WordW   = 64;
  localparam int unsigned CmdW    = 4;
  localparam int unsigned NibbleN = WordW / CmdW;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_SET  = 2'd1;
  localparam logic [1:0] REQ_DRAW = 2'd2;

  localparam logic [1:0] KIND_LINE = 2'd0;
  localparam logic [1:0] KIND_MOVE = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_UP_X   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_UP_Y   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LEFT_X = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LEFT_Y = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_STEP_X = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_STEP_Y = 3'd5;

  localparam logic [CmdW-1:0] CMD_UP         = 4'd0;
  localparam logic [CmdW-1:0] CMD_DOWN       = 4'd1;
  localparam logic [CmdW-1:0] CMD_LEFT       = 4'd2;
  localparam logic [CmdW-1:0] CMD_RIGHT      = 4'd3;
  localparam logic [CmdW-1:0] CMD_UP_RIGHT   = 4'd4;
  localparam logic [CmdW-1:0] CMD_DOWN_RIGHT = 4'd5;
  localparam logic [CmdW-1:0] CMD_DOWN_LEFT  = 4'd6;
  localparam logic [CmdW-1:0] CMD_UP_LEFT    = 4'd7;
  localparam logic [CmdW-1:0] CMD_PEN_UP     = 4'd8;
  localparam logic [CmdW-1:0] CMD_PEN_DOWN   = 4'd9;
  localparam logic [CmdW-1:0] CMD_UP2        = 4'd10;
  localparam logic [CmdW-1:0] CMD_DOWN2      = 4'd11;
  localparam logic [CmdW-1:0] CMD_LEFT2      = 4'd12;
  localparam logic [CmdW-1:0] CMD_RIGHT2     = 4'd13;
  localparam logic [CmdW-1:0] CMD_STOP       = 4'd14;
  localparam logic [CmdW-1:0] CMD_DOWN4      = 4'd15;

  localparam logic [CodeW-1:0] LC_FIRST = 7'd97;
  localparam logic [CodeW-1:0] LC_LAST  = 7'd122;

  localparam logic [CoordW-1:0] RST_UP_X   = 32'h0000_0000;
  localparam logic [CoordW-1:0] RST_UP_Y   = 32'h0001_0000;
  localparam logic [CoordW-1:0] RST_LEFT_X = 32'hFFFF_0000;
  localparam logic [CoordW-1:0] RST_LEFT_Y = 32'h0000_0000;
  localparam logic [CoordW-1:0] RST_STEP_X = 32'h0006_0000;
  localparam logic [CoordW-1:0] RST_STEP_Y = 32'h0000_0000;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } vec_t;

  typedef struct packed {
    vec_t u;
    vec_t l;
    vec_t u_plus_l;
    vec_t u_minus_l;
    vec_t u_twice;
    vec_t l_twice;
    vec_t u_down4;
  } base_set_t;

  typedef struct packed {
    logic is_move;
    logic pen_up;
    logic ink_on;
    logic stop;
    vec_t to;
  } stroke_t;

endpackage

// File: rtl/sfvg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfvg_if
// Request, result and register write channels of the vector generator.
// ----------------------------------------------------------------------------
interface sfvg_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic [6:0]          char_code;
  logic [63:0]         glyph_word;
  logic signed [31:0]  start_x;
  logic signed [31:0]  start_y;

  modport source (output valid, req_type, char_code, glyph_word, start_x, start_y,
                  input ready);
  modport sink   (input valid, req_type, char_code, glyph_word, start_x, start_y,
                  output ready);
endinterface

interface sfvg_out_if;
  logic                valid;
  logic                ready;
  logic [1:0]          seg_kind;
  logic signed [31:0]  from_x;
  logic signed [31:0]  from_y;
  logic signed [31:0]  to_x;
  logic signed [31:0]  to_y;
  logic                last_result;

  modport source (output valid, seg_kind, from_x, from_y, to_x, to_y, last_result,
                  input ready);
  modport sink   (input valid, seg_kind, from_x, from_y, to_x, to_y, last_result,
                  output ready);
endinterface

interface sfvg_cfg_if;
  logic               valid;
  logic               ready;
  logic [2:0]         index;
  logic signed [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/stroke_font_vector_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stroke_font_vector_generator_unit
// Vector stroke character generator with a host-loaded glyph store.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. A load or set-start request is accepted
// and then answered with an acknowledge item. A draw reads the glyph store as
// it is accepted, then walks the stroke commands up to and including a stop (at
// most 16), one command per cycle through the pen adder, and then places the
// final move to the next origin. A result item that has not been taken holds
// the walk or the acknowledge only where a new item must be placed, so a line
// command waits while the result channel is full. Glyph entries must be loaded
// before they are drawn.
module stroke_font_vector_generator_unit
  import sfvg_pkg::*;
#(
  parameter int unsigned NUM_GLYPHS        = 128,
  parameter int unsigned STROKES_PER_GLYPH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sfvg_in_if.sink       in_if,
  sfvg_out_if.source    out_if,
  sfvg_cfg_if.sink      cfg_if
);

  localparam int unsigned AddrW = $clog2(NUM_GLYPHS);
  localparam int unsigned WalkN = (STROKES_PER_GLYPH < NibbleN) ? STROKES_PER_GLYPH : NibbleN;
  localparam logic [3:0]  IdxLast = 4'(WalkN - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_ACK, ST_WALK, ST_MOVE} state_e;

  // code modulo store depth, for codes below nine times the store depth
  function automatic logic [AddrW-1:0] slot_of(input logic [CodeW-1:0] code);
    logic [8:0] v;
    v = {2'b00, code};
    for (int i = 0; i < 8; i++) begin
      if (v >= 9'(NUM_GLYPHS)) begin
        v = v - 9'(NUM_GLYPHS);
      end
    end
    return v[AddrW-1:0];
  endfunction

  state_e            state_q;
  logic [3:0]        idx_q;
  logic              half_q;
  logic              down_q;
  logic              ack_load_q;
  vec_t              pen_q;
  vec_t              origin_q;
  vec_t              up_q, left_q, step_q;
  vec_t              next_origin;

  logic              out_valid_q;
  logic [1:0]        seg_kind_q;
  vec_t              from_q, to_q;
  logic              last_q;

  logic              in_acc;
  logic              can_load;
  logic              out_load;
  logic [AddrW-1:0]  slot;
  logic [WordW-1:0]  glyph;
  logic [CmdW-1:0]   cmd;
  base_set_t         base;
  stroke_t           stroke;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign can_load    = !out_valid_q || out_if.ready;
  assign out_load    = can_load && ((state_q == ST_ACK) || (state_q == ST_MOVE) ||
                       ((state_q == ST_WALK) && stroke.is_move && down_q));
  assign slot        = slot_of(in_if.char_code);
  assign cmd         = glyph[{idx_q, 2'b00} +: CmdW];
  assign next_origin.x = origin_q.x + step_q.x;
  assign next_origin.y = origin_q.y + step_q.y;

  assign cfg_if.ready = 1'b1;

  assign out_if.valid       = out_valid_q;
  assign out_if.seg_kind    = seg_kind_q;
  assign out_if.from_x      = from_q.x;
  assign out_if.from_y      = from_q.y;
  assign out_if.to_x        = to_q.x;
  assign out_if.to_y        = to_q.y;
  assign out_if.last_result = last_q;

  sfvg_glyph_ram #(
    .Depth (NUM_GLYPHS),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_if.req_type == REQ_LOAD)),
    .waddr_i (slot),
    .wdata_i (in_if.glyph_word),
    .re_i    (in_acc && (in_if.req_type == REQ_DRAW)),
    .raddr_i (slot),
    .rdata_o (glyph)
  );

  sfvg_vec_table u_vec (
    .clk_i  (clk_i),
    .up_i   (up_q),
    .left_i (left_q),
    .base_o (base)
  );

  sfvg_stroke_unit u_stroke (
    .cmd_i    (cmd),
    .half_i   (half_q),
    .pen_i    (pen_q),
    .base_i   (base),
    .stroke_o (stroke)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q   <= '{x: RST_UP_X, y: RST_UP_Y};
      left_q <= '{x: RST_LEFT_X, y: RST_LEFT_Y};
      step_q <= '{x: RST_STEP_X, y: RST_STEP_Y};
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_UP_X:   up_q.x   <= cfg_if.data;
        CFG_UP_Y:   up_q.y   <= cfg_if.data;
        CFG_LEFT_X: left_q.x <= cfg_if.data;
        CFG_LEFT_Y: left_q.y <= cfg_if.data;
        CFG_STEP_X: step_q.x <= cfg_if.data;
        CFG_STEP_Y: step_q.y <= cfg_if.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      half_q      <= 1'b0;
      down_q      <= 1'b0;
      ack_load_q  <= 1'b0;
      pen_q       <= '0;
      origin_q    <= '0;
      out_valid_q <= 1'b0;
      seg_kind_q  <= KIND_ACK;
      from_q      <= '0;
      to_q        <= '0;
      last_q      <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !out_if.ready);
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_if.req_type)
              REQ_LOAD: begin
                ack_load_q <= 1'b1;
                state_q    <= ST_ACK;
              end
              REQ_SET: begin
                pen_q      <= '{x: in_if.start_x, y: in_if.start_y};
                origin_q   <= '{x: in_if.start_x, y: in_if.start_y};
                ack_load_q <= 1'b0;
                state_q    <= ST_ACK;
              end
              REQ_DRAW: begin
                half_q  <= (in_if.char_code >= LC_FIRST) && (in_if.char_code <= LC_LAST);
                down_q  <= 1'b0;
                idx_q   <= '0;
                state_q <= ST_WALK;
              end
              default: ;
            endcase
          end
        end
        ST_ACK: begin
          if (can_load) begin
            seg_kind_q  <= KIND_ACK;
            from_q      <= '0;
            to_q        <= ack_load_q ? '0 : pen_q;
            last_q      <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_WALK: begin
          if (stroke.stop) begin
            state_q <= ST_MOVE;
          end else if (!(stroke.is_move && down_q && !can_load)) begin
            if (stroke.is_move) begin
              pen_q <= stroke.to;
              if (down_q) begin
                seg_kind_q  <= KIND_LINE;
                from_q      <= pen_q;
                to_q        <= stroke.to;
                last_q      <= 1'b0;
              end
            end
            if (stroke.pen_up) begin
              down_q <= 1'b0;
            end
            if (stroke.ink_on) begin
              down_q <= 1'b1;
            end
            if (idx_q == IdxLast) begin
              state_q <= ST_MOVE;
            end else begin
              idx_q <= idx_q + 4'd1;
            end
          end
        end
        ST_MOVE: begin
          if (can_load) begin
            seg_kind_q  <= KIND_MOVE;
            from_q      <= pen_q;
            to_q        <= next_origin;
            last_q      <= 1'b1;
            pen_q       <= next_origin;
            origin_q    <= next_origin;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/sfvg_glyph_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfvg_glyph_ram
// Glyph store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sfvg_glyph_ram
  import sfvg_pkg::*;
#(
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WordW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WordW-1:0] rdata_o
);

  logic [WordW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/sfvg_vec_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfvg_vec_table
// Registered base vectors formed from the up and left registers.
// ----------------------------------------------------------------------------
module sfvg_vec_table
  import sfvg_pkg::*;
(
  input  logic      clk_i,
  input  vec_t      up_i,
  input  vec_t      left_i,
  output base_set_t base_o
);

  always_ff @(posedge clk_i) begin
    base_o.u           <= up_i;
    base_o.l           <= left_i;
    base_o.u_plus_l.x  <= up_i.x + left_i.x;
    base_o.u_plus_l.y  <= up_i.y + left_i.y;
    base_o.u_minus_l.x <= up_i.x - left_i.x;
    base_o.u_minus_l.y <= up_i.y - left_i.y;
    base_o.u_twice.x   <= {up_i.x[CoordW-2:0], 1'b0};
    base_o.u_twice.y   <= {up_i.y[CoordW-2:0], 1'b0};
    base_o.l_twice.x   <= {left_i.x[CoordW-2:0], 1'b0};
    base_o.l_twice.y   <= {left_i.y[CoordW-2:0], 1'b0};
    base_o.u_down4.x   <= 32'd0 - {up_i.x[CoordW-3:0], 2'b00};
    base_o.u_down4.y   <= 32'd0 - {up_i.y[CoordW-3:0], 2'b00};
  end

endmodule

// File: rtl/sfvg_stroke_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfvg_stroke_unit
// Decodes one stroke command and forms the pen position after the move.
// ----------------------------------------------------------------------------
module sfvg_stroke_unit
  import sfvg_pkg::*;
(
  input  logic [CmdW-1:0] cmd_i,
  input  logic            half_i,
  input  vec_t            pen_i,
  input  base_set_t       base_i,
  output stroke_t         stroke_o
);

  vec_t base;
  vec_t vec;
  logic neg;

  always_comb begin
    base = base_i.u;
    neg  = 1'b0;
    stroke_o.is_move  = 1'b1;
    stroke_o.pen_up   = 1'b0;
    stroke_o.ink_on   = 1'b0;
    stroke_o.stop     = 1'b0;
    unique case (cmd_i) inside
      CMD_UP:                  base = base_i.u;
      CMD_DOWN:       begin base = base_i.u;         neg = 1'b1; end
      CMD_LEFT:                base = base_i.l;
      CMD_RIGHT:      begin base = base_i.l;         neg = 1'b1; end
      CMD_UP_RIGHT:            base = base_i.u_minus_l;
      CMD_DOWN_RIGHT: begin base = base_i.u_plus_l;  neg = 1'b1; end
      CMD_DOWN_LEFT:  begin base = base_i.u_minus_l; neg = 1'b1; end
      CMD_UP_LEFT:             base = base_i.u_plus_l;
      CMD_UP2:                 base = base_i.u_twice;
      CMD_DOWN2:      begin base = base_i.u_twice;   neg = 1'b1; end
      CMD_LEFT2:               base = base_i.l_twice;
      CMD_RIGHT2:     begin base = base_i.l_twice;   neg = 1'b1; end
      CMD_DOWN4:               base = base_i.u_down4;
      CMD_PEN_UP:     begin stroke_o.is_move = 1'b0; stroke_o.pen_up = 1'b1; end
      CMD_PEN_DOWN:   begin stroke_o.is_move = 1'b0; stroke_o.ink_on = 1'b1; end
      default:        begin stroke_o.is_move = 1'b0; stroke_o.stop = 1'b1; end
    endcase

    // lower-case glyphs at half size
    if (half_i) begin
      vec.x = {base.x[CoordW-1], base.x[CoordW-1:1]};
      vec.y = {base.y[CoordW-1], base.y[CoordW-1:1]};
    end else begin
      vec = base;
    end

    if (neg) begin
      stroke_o.to.x = pen_i.x - vec.x;
      stroke_o.to.y = pen_i.y - vec.y;
    end else begin
      stroke_o.to.x = pen_i.x + vec.x;
      stroke_o.to.y = pen_i.y + vec.y;
    end
  end

endmodule

// File: rtl/sfvg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfvg_checker
// Port-level checks of the vector generator, bound to the top level.
// ----------------------------------------------------------------------------
module sfvg_checker
  import sfvg_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_req_type_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  seg_kind_i,
  input logic [31:0] from_x_i,
  input logic [31:0] from_y_i,
  input logic [31:0] to_x_i,
  input logic [31:0] to_y_i,
  input logic        last_result_i
);

  // stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(seg_kind_i) && $stable(to_x_i)
      && $stable(to_y_i) && $stable(from_x_i) && $stable(from_y_i)
      && $stable(last_result_i))
    else $error("stalled result item changed");

  // only lines are not final
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_result_i == (seg_kind_i != KIND_LINE)) && (seg_kind_i != 2'd3))
    else $error("last flag does not match kind");

  // acknowledge carries no start point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (seg_kind_i == KIND_ACK) |-> (from_x_i == 32'd0) && (from_y_i == 32'd0))
    else $error("acknowledge with nonzero from point");

  // a draw blocks new requests while it runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_req_type_i == REQ_DRAW) |=> !in_ready_i)
    else $error("request taken during draw");

endmodule

bind stroke_font_vector_generator_unit sfvg_checker u_sfvg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .in_req_type_i (in_if.req_type),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .seg_kind_i    (out_if.seg_kind),
  .from_x_i      (out_if.from_x),
  .from_y_i      (out_if.from_y),
  .to_x_i        (out_if.to_x),
  .to_y_i        (out_if.to_y),
  .last_result_i (out_if.last_result)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stroke font vector generator. A directed table
// covers glyph loads, start points at the coordinate extremes, every stroke
// command in full and half size, the lower-case bounds, early stops, the
// longest draw and reserved requests. Random phases follow with biased glyph
// words and several vector settings. Every segment item is checked against a
// local predictor of the pen walk, or against the item that a directed row gives.
// ----------------------------------------------------------------------------
module testbench;
  import sfvg_pkg::*;

  localparam logic [1:0]         REQ_RESERVED = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;
  localparam int                 GLYPHS       = 128;
  localparam int                 STROKES      = 16;
  localparam int                 SETTLE_CYC   = 24;
  localparam int                 STALL_LIMIT  = 4000;
  localparam int                 ITEMS_PER_PH = 95;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  code;
    logic [63:0] word;
    logic [31:0] sx;
    logic [31:0] sy;
  } request_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] tx;
    logic [31:0] ty;
    logic        last;
  } segment_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    segment_t seg;
  } stim_row_t;

  logic clk;
  logic rst_n;

  sfvg_in_if  in_bus ();
  sfvg_out_if out_bus ();
  sfvg_cfg_if cfg_bus ();

  stroke_font_vector_generator_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  // predictor state
  logic [63:0] glyph_mirror [GLYPHS];
  logic [31:0] pen_x, pen_y, origin_x, origin_y;
  logic [31:0] vec_up_x, vec_up_y, vec_left_x, vec_left_y, vec_step_x, vec_step_y;

  segment_t    expected_segs [$];
  stim_row_t   directed [$];
  logic [6:0]  drawable_codes [$];
  stim_row_t   cur_row;
  int          mismatches;
  int          idle_cycles;
  int          src_idle_pct;
  int          snk_idle_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic predict_request(input request_t rq);
    logic [63:0] word;
    logic [31:0] bx, by;
    logic [3:0]  cmd;
    logic        lc, down, stopped, neg;
    segment_t    seg;
    int          n;
    case (rq.req_type)
      REQ_LOAD: begin
        glyph_mirror[rq.code] = rq.word;
        seg = {KIND_ACK, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
        expected_segs.push_back(seg);
      end
      REQ_SET: begin
        pen_x = rq.sx;
        pen_y = rq.sy;
        origin_x = rq.sx;
        origin_y = rq.sy;
        seg = {KIND_ACK, 32'd0, 32'd0, rq.sx, rq.sy, 1'b1};
        expected_segs.push_back(seg);
      end
      REQ_DRAW: begin
        word = glyph_mirror[rq.code];
        lc = (rq.code >= LC_FIRST) && (rq.code <= LC_LAST);
        down = 1'b0;
        stopped = 1'b0;
        n = 0;
        for (int s = 0; s < STROKES; s++) begin
          cmd = word[4*s +: 4];
          if (!stopped) begin
            if (cmd == CMD_STOP) begin
              stopped = 1'b1;
            end else if (cmd == CMD_PEN_UP) begin
              down = 1'b0;
            end else if (cmd == CMD_PEN_DOWN) begin
              down = 1'b1;
            end else begin
              neg = 1'b0;
              case (cmd)
                CMD_UP: begin
                  bx = vec_up_x; by = vec_up_y;
                end
                CMD_DOWN: begin
                  bx = vec_up_x; by = vec_up_y; neg = 1'b1;
                end
                CMD_LEFT: begin
                  bx = vec_left_x; by = vec_left_y;
                end
                CMD_RIGHT: begin
                  bx = vec_left_x; by = vec_left_y; neg = 1'b1;
                end
                CMD_UP_RIGHT: begin
                  bx = vec_up_x - vec_left_x; by = vec_up_y - vec_left_y;
                end
                CMD_DOWN_RIGHT: begin
                  bx = vec_up_x + vec_left_x; by = vec_up_y + vec_left_y; neg = 1'b1;
                end
                CMD_DOWN_LEFT: begin
                  bx = vec_up_x - vec_left_x; by = vec_up_y - vec_left_y; neg = 1'b1;
                end
                CMD_UP_LEFT: begin
                  bx = vec_up_x + vec_left_x; by = vec_up_y + vec_left_y;
                end
                CMD_UP2: begin
                  bx = vec_up_x << 1; by = vec_up_y << 1;
                end
                CMD_DOWN2: begin
                  bx = vec_up_x << 1; by = vec_up_y << 1; neg = 1'b1;
                end
                CMD_LEFT2: begin
                  bx = vec_left_x << 1; by = vec_left_y << 1;
                end
                CMD_RIGHT2: begin
                  bx = vec_left_x << 1; by = vec_left_y << 1; neg = 1'b1;
                end
                default: begin
                  bx = 32'd0 - (vec_up_x << 2); by = 32'd0 - (vec_up_y << 2);
                end
              endcase
              // half size for lower case, sign kept
              if (lc) begin
                bx = {bx[31], bx[31:1]};
                by = {by[31], by[31:1]};
              end
              if (neg) begin
                bx = 32'd0 - bx;
                by = 32'd0 - by;
              end
              if (down && n < 15) begin
                seg = {KIND_LINE, pen_x, pen_y, pen_x + bx, pen_y + by, 1'b0};
                expected_segs.push_back(seg);
                n++;
              end
              pen_x = pen_x + bx;
              pen_y = pen_y + by;
            end
          end
        end
        origin_x = origin_x + vec_step_x;
        origin_y = origin_y + vec_step_y;
        seg = {KIND_MOVE, pen_x, pen_y, origin_x, origin_y, 1'b1};
        expected_segs.push_back(seg);
        pen_x = origin_x;
        pen_y = origin_y;
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    segment_t exp_seg;
    logic     moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        moved = 1'b1;
        if (expected_segs.size() == 0) begin
          $error("segment item with none expected: kind %0d to %h,%h",
                 out_bus.seg_kind, out_bus.to_x, out_bus.to_y);
          mismatches++;
        end else begin
          exp_seg = expected_segs.pop_front();
          check_field("seg_kind", 32'(exp_seg.kind), 32'(out_bus.seg_kind));
          check_field("from_x", exp_seg.fx, out_bus.from_x);
          check_field("from_y", exp_seg.fy, out_bus.from_y);
          check_field("to_x", exp_seg.tx, out_bus.to_x);
          check_field("to_y", exp_seg.ty, out_bus.to_y);
          check_field("last_result", 32'(exp_seg.last), 32'(out_bus.last_result));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        moved = 1'b1;
        predict_request({in_bus.req_type, in_bus.char_code, in_bus.glyph_word,
                         in_bus.start_x, in_bus.start_y});
        if (cur_row.typed) begin
          expected_segs[expected_segs.size() - 1] = cur_row.seg;
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        moved = 1'b1;
        case (cfg_bus.index)
          CFG_UP_X:   vec_up_x   = cfg_bus.data;
          CFG_UP_Y:   vec_up_y   = cfg_bus.data;
          CFG_LEFT_X: vec_left_x = cfg_bus.data;
          CFG_LEFT_Y: vec_left_y = cfg_bus.data;
          CFG_STEP_X: vec_step_x = cfg_bus.data;
          CFG_STEP_Y: vec_step_y = cfg_bus.data;
          default: begin
          end
        endcase
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(negedge clk);
    $display("FAIL");
    $finish;
  end

  task automatic send_request(input stim_row_t row);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    cur_row = row;
    in_bus.valid      = 1'b1;
    in_bus.req_type   = row.req.req_type;
    in_bus.char_code  = row.req.code;
    in_bus.glyph_word = row.req.word;
    in_bus.start_x    = row.req.sx;
    in_bus.start_y    = row.req.sy;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_bus.valid = 1'b0;
    while (expected_segs.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic write_vectors(input logic [31:0] ux, uy, lx, ly, sx, sy);
    wait_drained();
    repeat (SETTLE_CYC) @(negedge clk);
    write_register(CFG_UP_X, ux);
    write_register(CFG_UP_Y, uy);
    write_register(CFG_LEFT_X, lx);
    write_register(CFG_LEFT_Y, ly);
    write_register(CFG_STEP_X, sx);
    write_register(CFG_STEP_Y, sy);
    write_register(CFG_SPARE_LO, $urandom);
    write_register(CFG_SPARE_HI, $urandom);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(7))
      0: pick_coord = 32'h7FFF_FFFF;
      1: pick_coord = 32'h8000_0000;
      2: pick_coord = 32'h0000_0000;
      3: pick_coord = 32'hFFFF_FFFF;
      default: pick_coord = $urandom;
    endcase
  endfunction

  function automatic logic [31:0] small_coord();
    logic [31:0] v;
    v = $urandom_range(262143);
    small_coord = v - 32'd131072;
  endfunction

  // mostly well-formed strokes: pen down first, moves, then a stop somewhere
  function automatic logic [63:0] make_glyph();
    logic [63:0] w;
    logic [3:0]  c;
    int          len;
    w = {$urandom, $urandom};
    if ($urandom_range(2) != 0) begin
      len = $urandom_range(STROKES);
      for (int s = 0; s < STROKES; s++) begin
        if (s == len) begin
          c = CMD_STOP;
        end else if (s > len) begin
          c = 4'($urandom_range(15));
        end else if (s == 0 && $urandom_range(3) != 0) begin
          c = CMD_PEN_DOWN;
        end else begin
          case ($urandom_range(9))
            0: c = CMD_PEN_UP;
            1: c = CMD_PEN_DOWN;
            default: begin
              c = 4'($urandom_range(15));
              while (c == CMD_PEN_UP || c == CMD_PEN_DOWN || c == CMD_STOP) begin
                c = 4'($urandom_range(15));
              end
            end
          endcase
        end
        w[4*s +: 4] = c;
      end
    end
    make_glyph = w;
  endfunction

  function automatic stim_row_t row_of(input logic [1:0] rt, input logic [6:0] code,
                                       input logic [63:0] word, input logic [31:0] sx,
                                       input logic [31:0] sy, input logic typed,
                                       input segment_t seg);
    row_of.req   = {rt, code, word, sx, sy};
    row_of.typed = typed;
    row_of.seg   = seg;
  endfunction

  initial begin : stimulus
    localparam logic [63:0] EVERY_CMD  = 64'h08FD_CBA7_6543_2109;
    localparam logic [63:0] LONGEST    = 64'h0000_0000_0000_0009;
    localparam logic [63:0] EARLY_STOP = 64'h1111_1111_1111_1E09;
    localparam logic [63:0] STOP_ONLY  = 64'h0000_0000_0000_000E;
    segment_t  ack0;
    segment_t  none;
    stim_row_t row;
    int        pick;

    rst_n = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    src_idle_pct = 15;
    snk_idle_pct = 77;
    cur_row = '0;
    in_bus.valid = 1'b0;
    in_bus.req_type = REQ_LOAD;
    in_bus.char_code = '0;
    in_bus.glyph_word = '0;
    in_bus.start_x = '0;
    in_bus.start_y = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_UP_X;
    cfg_bus.data = '0;
    pen_x = '0;
    pen_y = '0;
    origin_x = '0;
    origin_y = '0;
    vec_up_x = RST_UP_X;
    vec_up_y = RST_UP_Y;
    vec_left_x = RST_LEFT_X;
    vec_left_y = RST_LEFT_Y;
    vec_step_x = RST_STEP_X;
    vec_step_y = RST_STEP_Y;
    for (int g = 0; g < GLYPHS; g++) glyph_mirror[g] = '0;

    ack0 = {KIND_ACK, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
    none = '0;
    directed.push_back(row_of(REQ_SET, 7'd0, '0, 32'd0, 32'd0, 1'b1, ack0));
    directed.push_back(row_of(REQ_LOAD, 7'd0, 64'd0, '0, '0, 1'b1, ack0));
    directed.push_back(row_of(REQ_LOAD, 7'd127, '1, '0, '0, 1'b1, ack0));
    directed.push_back(row_of(REQ_LOAD, 7'd65, EVERY_CMD, '0, '0, 1'b1, ack0));
    directed.push_back(row_of(REQ_LOAD, 7'd97, EVERY_CMD, '0, '0, 1'b1, ack0));
    directed.push_back(row_of(REQ_LOAD, 7'd96, EVERY_CMD, '0, '0, 1'b1, ack0));
    directed.push_back(row_of(REQ_LOAD, 7'd122, EVERY_CMD, '0, '0, 1'b1, ack0));
    directed.push_back(row_of(REQ_LOAD, 7'd123, EVERY_CMD, '0, '0, 1'b1, ack0));
    directed.push_back(row_of(REQ_LOAD, 7'd1, LONGEST, '0, '0, 1'b1, ack0));
    directed.push_back(row_of(REQ_LOAD, 7'd2, EARLY_STOP, '0, '0, 1'b1, ack0));
    directed.push_back(row_of(REQ_LOAD, 7'd3, STOP_ONLY, '0, '0, 1'b1, ack0));
    // first draw after reset: straight to the next origin
    directed.push_back(row_of(REQ_DRAW, 7'd3, '0, '0, '0, 1'b1,
                              {KIND_MOVE, 32'd0, 32'd0, RST_STEP_X, 32'd0, 1'b1}));
    directed.push_back(row_of(REQ_DRAW, 7'd65, '0, '0, '0, 1'b0, none));
    directed.push_back(row_of(REQ_DRAW, 7'd97, '0, '0, '0, 1'b0, none));
    directed.push_back(row_of(REQ_DRAW, 7'd96, '0, '0, '0, 1'b0, none));
    directed.push_back(row_of(REQ_DRAW, 7'd122, '0, '0, '0, 1'b0, none));
    directed.push_back(row_of(REQ_DRAW, 7'd123, '0, '0, '0, 1'b0, none));
    directed.push_back(row_of(REQ_DRAW, 7'd0, '0, '0, '0, 1'b0, none));
    directed.push_back(row_of(REQ_DRAW, 7'd127, '0, '0, '0, 1'b0, none));
    directed.push_back(row_of(REQ_DRAW, 7'd1, '0, '0, '0, 1'b0, none));
    directed.push_back(row_of(REQ_DRAW, 7'd2, '0, '0, '0, 1'b0, none));
    directed.push_back(row_of(REQ_RESERVED, 7'd5, '1, '1, '1, 1'b0, none));
    directed.push_back(row_of(REQ_SET, 7'd0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
                              {KIND_ACK, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1}));
    directed.push_back(row_of(REQ_DRAW, 7'd1, '0, '0, '0, 1'b0, none));
    directed.push_back(row_of(REQ_SET, 7'd0, '0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
                              {KIND_ACK, 32'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1}));
    directed.push_back(row_of(REQ_DRAW, 7'd65, '0, '0, '0, 1'b0, none));
    drawable_codes.delete();
    drawable_codes.push_back(7'd0);
    drawable_codes.push_back(7'd1);
    drawable_codes.push_back(7'd65);
    drawable_codes.push_back(7'd97);
    drawable_codes.push_back(7'd127);

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed[i]) send_request(directed[i]);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          write_vectors(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                        pick_coord(), pick_coord());
        end
        1: begin
          src_idle_pct = 77;
          snk_idle_pct = 15;
          write_vectors(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'hFFFF_FFFF, 32'h8000_0000);
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
          write_vectors(small_coord(), small_coord(), small_coord(), small_coord(),
                        small_coord(), small_coord());
        end
      endcase
      for (int k = 0; k < ITEMS_PER_PH; k++) begin
        if (k == ITEMS_PER_PH / 2 || $urandom_range(39) == 0) wait_drained();
        row = '0;
        row.req.code = 7'($urandom_range(127));
        row.req.word = {$urandom, $urandom};
        row.req.sx = $urandom;
        row.req.sy = $urandom;
        pick = $urandom_range(99);
        if (pick < 15) begin
          row.req.req_type = REQ_LOAD;
          row.req.word = make_glyph();
          drawable_codes.push_back(row.req.code);
        end else if (pick < 25) begin
          row.req.req_type = REQ_SET;
          row.req.sx = pick_coord();
          row.req.sy = pick_coord();
        end else if (pick < 95) begin
          row.req.req_type = REQ_DRAW;
          row.req.code = drawable_codes[$urandom_range(drawable_codes.size() - 1)];
        end else begin
          row.req.req_type = REQ_RESERVED;
        end
        send_request(row);
      end
    end

    wait_drained();
    repeat (SETTLE_CYC) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sfvg_pkg.sv
rtl/sfvg_if.sv
rtl/sfvg_glyph_ram.sv
rtl/sfvg_vec_table.sv
rtl/sfvg_stroke_unit.sv
rtl/stroke_font_vector_generator_unit.sv
rtl/sfvg_checker.sv
sim/testbench.sv
